### hdl/sfplo_pkg.sv
`timescale 1ns / 1ps

package sfplo_pkg;

  localparam int unsigned NumChan       = 7;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned OffW          = 10;
  localparam int unsigned MinFrameBytes = 8;

  localparam logic [ChanW-1:0] HdrFirst   = 8'h2C;
  localparam logic [ChanW-1:0] HdrSecond  = 8'h12;
  localparam logic [ChanW-1:0] Terminator = 8'h5B;

  localparam logic signed [OffW-1:0] OffCentre   = 10'sd0;
  localparam logic signed [OffW-1:0] OffRightIn  = 10'sd400;
  localparam logic signed [OffW-1:0] OffRightOut = 10'sd500;
  localparam logic signed [OffW-1:0] OffLeftOut  = -10'sd500;
  localparam logic signed [OffW-1:0] OffLeftIn   = -10'sd400;

  typedef logic [ChanW-1:0] byte_t;
  typedef byte_t [NumChan-1:0] chan_arr_t;

  typedef enum logic [1:0] {
    PhIdle,
    PhHdr,
    PhCollect,
    PhCheck
  } phase_e;

  typedef struct packed {
    logic latch;
    logic trail_err;
  } parse_ev_t;

  typedef struct packed {
    logic                   hit;
    logic signed [OffW-1:0] off;
  } off_dec_t;

  // left, centre, right line sensors
  function automatic off_dec_t decode_offset(byte_t l, byte_t c, byte_t r);
    off_dec_t res;
    res.hit = 1'b1;
    res.off = OffCentre;
    if (l == 8'd0 && c == 8'd1 && r == 8'd0) begin
      res.off = OffCentre;
    end else if (l == 8'd0 && c == 8'd1 && r == 8'd1) begin
      res.off = OffRightIn;
    end else if (l == 8'd0 && c == 8'd0 && r == 8'd1) begin
      res.off = OffRightOut;
    end else if (l == 8'd1 && c == 8'd0 && r == 8'd0) begin
      res.off = OffLeftOut;
    end else if (l == 8'd1 && c == 8'd1 && r == 8'd0) begin
      res.off = OffLeftIn;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

### hdl/sfplo_parser.sv
`timescale 1ns / 1ps

module sfplo_parser
  import sfplo_pkg::*;
#(
  parameter int unsigned FRAME_MAX = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  byte_t     rx_byte_i,
  output parse_ev_t ev_d_o,
  output parse_ev_t ev_q_o,
  output chan_arr_t window_o,
  output phase_e    phase_o
);

  localparam int unsigned CntW = $clog2(FRAME_MAX + 1);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  chan_arr_t       win_q, win_d;
  logic            term_q, term_d;
  parse_ev_t       ev_q, ev_d;

  // last seven stored bytes, index 0 newest
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    win_d   = win_q;
    term_d  = term_q;
    ev_d    = ev_q;
    cnt_inc = cnt_q + CntW'(1);
    if (accept_i) begin
      ev_d = '0;
      case (phase_q)
        PhIdle: begin
          cnt_d = '0;
          if (rx_byte_i == HdrFirst) begin
            cnt_d   = CntW'(1);
            win_d   = {win_q[NumChan-2:0], rx_byte_i};
            phase_d = PhHdr;
          end
        end
        PhHdr: begin
          if (rx_byte_i == HdrSecond) begin
            cnt_d   = cnt_inc;
            win_d   = {win_q[NumChan-2:0], rx_byte_i};
            phase_d = PhCollect;
          end else begin
            cnt_d   = '0;
            phase_d = PhIdle;
          end
        end
        PhCollect: begin
          cnt_d = cnt_inc;
          win_d = {win_q[NumChan-2:0], rx_byte_i};
          if (cnt_inc >= CntW'(FRAME_MAX) || rx_byte_i == Terminator) begin
            phase_d  = PhCheck;
            term_d   = (rx_byte_i == Terminator);
            ev_d.latch = (cnt_inc >= CntW'(MinFrameBytes));
          end
        end
        PhCheck: begin
          ev_d.trail_err = ~term_q;
          cnt_d          = '0;
          phase_d        = PhIdle;
        end
        default: begin
          cnt_d   = '0;
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      term_q  <= 1'b0;
      ev_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      term_q  <= term_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign ev_d_o   = ev_d;
  assign ev_q_o   = ev_q;
  assign window_o = win_q;
  assign phase_o  = phase_q;

endmodule

### hdl/sfplo_chan.sv
`timescale 1ns / 1ps

module sfplo_chan
  import sfplo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   latch_i,
  input  chan_arr_t              window_i,
  output chan_arr_t              chan_o,
  output logic signed [OffW-1:0] offset_o
);

  chan_arr_t              chan_q, chan_d;
  logic signed [OffW-1:0] off_q, off_d;
  off_dec_t               dec;

  // channel one is the oldest byte of the window
  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      chan_d[k] = window_i[NumChan-1-k];
    end
    dec   = decode_offset(chan_d[2], chan_d[3], chan_d[4]);
    off_d = dec.hit ? dec.off : off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      off_q  <= '0;
    end else if (latch_i) begin
      chan_q <= chan_d;
      off_q  <= off_d;
    end
  end

  assign chan_o   = chan_q;
  assign offset_o = off_q;

endmodule

### hdl/sensor_frame_parser_line_offset.sv
`timescale 1ns / 1ps
// An accepted input word yields its result word, registered, in the next cycle.
// Throughput: one word per cycle unless stalled; the single parser state update sets
// the pace. A new word is taken while the result slot is empty or being drained.
// Reset: asynchronous, active low; parser idle, channels and offset zero,
// no result pending.

module sensor_frame_parser_line_offset
  import sfplo_pkg::*;
#(
  parameter int unsigned FRAME_MAX = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // chan_one .. chan_seven, line_offset, zero pad
  output logic [1:0]  m_axis_tuser    // frame_latched, trailer_error
);

  logic                   in_acc;
  logic                   out_vld_q, out_vld_d;
  parse_ev_t              ev_d, ev_q;
  chan_arr_t              window;
  chan_arr_t              chan;
  logic signed [OffW-1:0] offset;
  phase_e                 phase;

  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  sfplo_parser #(
    .FRAME_MAX(FRAME_MAX)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .rx_byte_i(s_axis_tdata),
    .ev_d_o   (ev_d),
    .ev_q_o   (ev_q),
    .window_o (window),
    .phase_o  (phase)
  );

  sfplo_chan u_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .latch_i (in_acc & ev_d.latch),
    .window_i(window),
    .chan_o  (chan),
    .offset_o(offset)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (in_acc) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {ev_q.trail_err, ev_q.latch};
  assign m_axis_tdata  = {6'd0, offset, chan[6], chan[5], chan[4], chan[3],
                          chan[2], chan[1], chan[0]};

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ev_q.latch && ev_q.trail_err))
    else $error("latch and trailer error on one word");

  a_latch_then_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q.latch |-> phase == PhCheck)
    else $error("frame latched without entering check step");

  a_offset_on_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(offset) |-> ev_q.latch)
    else $error("line offset moved without a latch");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with empty result slot");

endmodule
